// File: hw/rtl/rtcm_pkg.sv
package rtcm_pkg;

    localparam int NODES_DEF   = 1024;
    localparam int VALUE_W_DEF = 32;

    localparam int KEY_W       = 21;
    localparam int DIGIT_W     = 3;
    localparam int LVL_W       = 3;
    localparam int TOP_LEVEL   = 6;
    localparam int COUNT_W     = 21;
    localparam int OUT_VALUE_W = 32;
    localparam int IN_VALUE_W  = 32;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;

    localparam logic [KEY_W-1:0] TOP_KEY = 21'h10FFFF;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK
    } seq_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0]     entry_count;
        logic                   was_present;
        logic [STATUS_W-1:0]    status;
        logic [OUT_VALUE_W-1:0] value_out;
    } result_t;

    // 3-bit digit of the key for a trie level, level 6 at the top
    function automatic logic [DIGIT_W-1:0] digit_at(input logic [KEY_W-1:0] key,
                                                    input logic [LVL_W-1:0] lvl);
        logic [DIGIT_W-1:0] d;
        case (lvl)
            3'd0:    d = key[2:0];
            3'd1:    d = key[5:3];
            3'd2:    d = key[8:6];
            3'd3:    d = key[11:9];
            3'd4:    d = key[14:12];
            3'd5:    d = key[17:15];
            3'd6:    d = key[20:18];
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

// File: hw/rtl/radix_trie_codepoint_map_core.sv
// Flow: the root read starts in the accept cycle, then S_WALK follows the trie down
//   the seven levels (6 to 0), one dependent slot read per level; misses and
//   out-of-range keys finish earlier. s_tready stays low until the last result is
//   issued, since the walk chains its reads through the single slot memory.
// Reset: aresetn low clears control state; afterwards a clearing pass writes all
//   NODES*8 slots with s_tready held low.
module radix_trie_codepoint_map_core #(
    parameter int NODES   = rtcm_pkg::NODES_DEF,
    parameter int VALUE_W = rtcm_pkg::VALUE_W_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // codepoint[20:0], value_in[52:21], zero[55:53]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // value_out[31:0], status[33:32], was_present[34],
                                   // entry_count[55:35]
);
    import rtcm_pkg::*;

    localparam int NODE_W = $clog2(NODES);
    localparam int ADDR_W = NODE_W + 3;
    localparam int SLOT_W = (VALUE_W + 1 > NODE_W) ? VALUE_W + 1 : NODE_W;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [SLOT_W-1:0] mem_wdata, mem_rdata;
    logic              res_valid;
    result_t           res;
    logic              out_free;

    logic              m_tvalid_reg, m_tvalid_next;
    result_t           m_data_reg, m_data_next;

    rtcm_slot_mem #(
        .DEPTH  (NODES * 8),
        .DATA_W (SLOT_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rtcm_seq #(
        .NODES   (NODES),
        .VALUE_W (VALUE_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_key    (s_tdata[20:0]),
        .in_value  (s_tdata[52:21]),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register: free when empty or draining this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            m_data_next   = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: hw/rtl/rtcm_slot_mem.sv
module rtcm_slot_mem #(
    parameter int DEPTH  = 8192,
    parameter int DATA_W = 33,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] slot_mem [0:DEPTH-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            slot_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= slot_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/rtcm_seq.sv
module rtcm_seq #(
    parameter int NODES   = 1024,
    parameter int VALUE_W = 32,
    localparam int NODE_W = $clog2(NODES),
    localparam int ADDR_W = NODE_W + 3,
    localparam int SLOT_W = (VALUE_W + 1 > NODE_W) ? VALUE_W + 1 : NODE_W
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rtcm_pkg::KIND_W-1:0]         in_kind,
    input  logic [rtcm_pkg::KEY_W-1:0]          in_key,
    input  logic [rtcm_pkg::IN_VALUE_W-1:0]     in_value,
    output logic                                mem_we,
    output logic [ADDR_W-1:0]                   mem_waddr,
    output logic [SLOT_W-1:0]                   mem_wdata,
    output logic                                mem_re,
    output logic [ADDR_W-1:0]                   mem_raddr,
    input  logic [SLOT_W-1:0]                   mem_rdata,
    input  logic                                out_free,
    output logic                                res_valid,
    output rtcm_pkg::result_t                   res
);
    import rtcm_pkg::*;

    localparam int DEPTH = NODES * 8;
    localparam int NF_W  = $clog2(NODES + 1);
    localparam int CP_W  = (VALUE_W < 32) ? VALUE_W : 32;

    seq_state_t               state_reg, state_next;
    logic [ADDR_W-1:0]        clr_reg, clr_next;
    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic [IN_VALUE_W-1:0]    val_reg, val_next;
    logic                     range_reg, range_next;
    logic [NODE_W-1:0]        node_reg, node_next;
    logic [LVL_W-1:0]         lvl_reg, lvl_next;
    logic [NF_W-1:0]          nf_reg, nf_next;
    logic [COUNT_W-1:0]       count_reg, count_next;

    logic [DIGIT_W-1:0]       dig_cur, dig_down;
    logic                     child_ok;
    logic [NODE_W-1:0]        child;
    logic                     was;
    logic [VALUE_W-1:0]       val_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            nf_reg    <= NF_W'(2);
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            nf_reg    <= nf_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        range_reg <= range_next;
        node_reg  <= node_next;
        lvl_reg   <= lvl_next;
    end

    assign dig_cur  = digit_at(key_reg, lvl_reg);
    assign dig_down = digit_at(key_reg, lvl_reg - 3'd1);
    assign child_ok = ({1'b0, mem_rdata} < (SLOT_W + 1)'(NODES));
    assign child    = child_ok ? mem_rdata[NODE_W-1:0] : '0;
    assign was      = mem_rdata[VALUE_W];
    assign val_w    = VALUE_W'(val_reg[CP_W-1:0]);

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        kind_next  = kind_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        range_next = range_reg;
        node_next  = node_reg;
        lvl_next   = lvl_reg;
        nf_next    = nf_reg;
        count_next = count_reg;
        in_ready   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = {NODE_W'(1), in_key[20:18]};
        res_valid  = 1'b0;
        res        = '0;

        case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    // start the root read in the accept cycle
                    mem_re     = 1'b1;
                    kind_next  = in_kind;
                    key_next   = in_key;
                    val_next   = in_value;
                    range_next = (in_key > TOP_KEY);
                    node_next  = NODE_W'(1);
                    lvl_next   = LVL_W'(TOP_LEVEL);
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (range_reg) begin
                    if (out_free) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_RANGE;
                        state_next = S_IDLE;
                    end
                end else if (lvl_reg != '0) begin
                    if (child != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = {child, dig_down};
                        node_next = child;
                        lvl_next  = lvl_reg - 3'd1;
                    end else if (kind_reg == KIND_INSERT) begin
                        if (nf_reg >= NF_W'(NODES)) begin
                            if (out_free) begin
                                res_valid  = 1'b1;
                                res.status = STATUS_FULL;
                                state_next = S_IDLE;
                            end
                        end else begin
                            // link a fresh node; its slots are known zero
                            mem_we    = 1'b1;
                            mem_waddr = {node_reg, dig_cur};
                            mem_wdata = SLOT_W'(nf_reg[NODE_W-1:0]);
                            mem_re    = 1'b1;
                            mem_raddr = {nf_reg[NODE_W-1:0], dig_down};
                            node_next = nf_reg[NODE_W-1:0];
                            nf_next   = nf_reg + 1'b1;
                            lvl_next  = lvl_reg - 3'd1;
                        end
                    end else if (out_free) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_OK;
                        state_next = S_IDLE;
                    end
                end else if (out_free) begin
                    mem_waddr = {node_reg, dig_cur};
                    if (kind_reg == KIND_INSERT) begin
                        mem_we    = 1'b1;
                        mem_wdata = SLOT_W'({1'b1, val_w});
                        if (!was) begin
                            count_next = count_reg + 1'b1;
                        end
                    end else if (kind_reg == KIND_REMOVE) begin
                        mem_we = 1'b1;
                        if (was && count_reg != '0) begin
                            count_next = count_reg - 1'b1;
                        end
                    end else begin
                        res.value_out = OUT_VALUE_W'(mem_rdata[CP_W-1:0]);
                    end
                    res_valid       = 1'b1;
                    res.status      = STATUS_OK;
                    res.was_present = was;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        res.entry_count = count_next;
    end

    a_no_result_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result issued while output register is occupied");

    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nf_reg <= NF_W'(NODES))
        else $error("node allocator passed the pool size");

    a_sink_untouched: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg != S_CLEAR) |-> (mem_waddr[ADDR_W-1:3] != '0))
        else $error("write to the sink node");

    a_count_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> $past(res_valid))
        else $error("entry count moved without a result");

    a_alloc_on_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (nf_reg != $past(nf_reg)) |-> ($past(kind_reg) == KIND_INSERT))
        else $error("node allocated outside an insert");

endmodule

// File: tb/sv/tb_radix_trie_codepoint_map_core.sv
module tb_radix_trie_codepoint_map_core;
    import rtcm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;   // unused code, behaves as lookup
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_OFF_AT  = 120;
    localparam int HOLD_OFF_LEN = 300;
    localparam int DRAIN_CYCLES = 16;

    // Mirror of the trie: slot pool, bump allocator and entry count, plus the
    // results still owed by the block.
    class trie_map_scoreboard;
        logic [VALUE_W_DEF:0] slot_mem [NODES_DEF*8];
        int unsigned free_node;
        int unsigned live_entries;
        result_t     owed_q [$];
        int          errors;

        function new();
            foreach (slot_mem[i]) slot_mem[i] = '0;
            free_node    = 2;
            live_entries = 0;
            errors       = 0;
        endfunction

        function int unsigned child_node(int unsigned node, logic [DIGIT_W-1:0] d);
            logic [VALUE_W_DEF:0] c;
            c = slot_mem[node*8 + d];
            return (c < NODES_DEF) ? int'(c) : 0;
        endfunction

        function void note_input(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] cp,
                                 logic [IN_VALUE_W-1:0] val);
            result_t           r;
            int unsigned       node;
            int unsigned       c;
            int unsigned       idx;
            logic [DIGIT_W-1:0] d;
            bit                stuck;
            r     = '0;
            node  = 1;
            stuck = 0;
            if (cp > TOP_KEY) begin
                r.status = STATUS_RANGE;
            end else if (kind == KIND_INSERT) begin
                for (int lvl = TOP_LEVEL; lvl >= 1; lvl--) begin
                    if (!stuck) begin
                        d = cp[3*lvl +: 3];
                        c = child_node(node, d);
                        if (c == 0 && free_node >= NODES_DEF) begin
                            stuck = 1;
                        end else begin
                            // link a fresh node where the path ends
                            if (c == 0) begin
                                c = free_node;
                                free_node++;
                                slot_mem[node*8 + d] = (VALUE_W_DEF+1)'(c);
                            end
                            node = c;
                        end
                    end
                end
                if (stuck) begin
                    r.status = STATUS_FULL;
                end else begin
                    idx = node*8 + cp[2:0];
                    r.was_present = slot_mem[idx][VALUE_W_DEF];
                    if (!r.was_present) live_entries++;
                    slot_mem[idx] = {1'b1, val};
                end
            end else begin
                for (int lvl = TOP_LEVEL; lvl >= 1; lvl--) begin
                    if (node != 0) node = child_node(node, cp[3*lvl +: 3]);
                end
                if (node != 0) begin
                    idx = node*8 + cp[2:0];
                    r.was_present = slot_mem[idx][VALUE_W_DEF];
                    if (kind == KIND_REMOVE) begin
                        if (r.was_present && live_entries > 0) live_entries--;
                        slot_mem[idx] = '0;
                    end else begin
                        r.value_out = slot_mem[idx][VALUE_W_DEF-1:0];
                    end
                end
            end
            r.entry_count = COUNT_W'(live_entries);
            owed_q.insert(owed_q.size(), r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [55:0] data);
            result_t got;
            result_t want;
            got = data;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending: expected none, actual %h",
                         $time, data);
                return;
            end
            want = owed_q.pop_front();
            compare_field("value_out", want.value_out, got.value_out);
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("was_present", 32'(want.was_present), 32'(got.was_present));
            compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    trie_map_scoreboard sb;
    int          cycles = 0;
    int          sent = 0;
    bit          tx_idle = 1;
    bit          rx_idle = 1;
    logic [KEY_W-1:0] cluster_base [4];

    radix_trie_codepoint_map_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] cp,
                             input logic [IN_VALUE_W-1:0] val);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, val, cp};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(kind, cp, val);
        sent++;
        if (sent % 60 == 0) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
        end
        @(negedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(int cluster_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return KEY_W'($urandom_range('h110000, 'h1FFFFF));
        if (roll < cluster_pct)
            return cluster_base[$urandom_range(0, 3)] | KEY_W'($urandom_range(0, 63));
        return KEY_W'($urandom_range(0, 'h10FFFF));
    endfunction

    task automatic mixed_op(int cluster_pct);
        int               roll;
        logic [KIND_W-1:0] kind;
        roll = $urandom_range(0, 99);
        if (roll < 35)      kind = KIND_INSERT;
        else if (roll < 55) kind = KIND_REMOVE;
        else if (roll < 93) kind = KIND_LOOKUP;
        else                kind = KIND_SPARE;
        send_item(kind, pick_key(cluster_pct), $urandom());
    endtask

    // result side: random stalls, one long hold-off to back up the input
    initial begin
        int stall;
        int got;
        got = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = rx_idle ? $urandom_range(0, 11) : 0;
            if (got == HOLD_OFF_AT) stall = HOLD_OFF_LEN;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
            got++;
            @(negedge aclk);
        end
    end

    initial begin
        int n;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        sb = new();
        cluster_base[0] = 21'h000000;
        cluster_base[1] = 21'h10FFC0;
        cluster_base[2] = KEY_W'($urandom_range(0, 'h10FFFF)) & ~21'h3F;
        cluster_base[3] = KEY_W'($urandom_range(0, 'h10FFFF)) & ~21'h3F;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extremes, overwrite, removes, rejected keys
        send_item(KIND_LOOKUP, 21'h000000, 32'h0);
        send_item(KIND_INSERT, 21'h000000, 32'hFFFFFFFF);
        send_item(KIND_LOOKUP, 21'h000000, 32'h0);
        send_item(KIND_INSERT, 21'h10FFFF, 32'h00000000);
        send_item(KIND_LOOKUP, 21'h10FFFF, 32'hFFFFFFFF);
        send_item(KIND_INSERT, 21'h110000, 32'h5A5A5A5A);
        send_item(KIND_LOOKUP, 21'h1FFFFF, 32'h0);
        send_item(KIND_REMOVE, 21'h1FFFFF, 32'h0);
        send_item(KIND_INSERT, 21'h10FFFF, 32'hA5A5A5A5);
        send_item(KIND_SPARE,  21'h10FFFF, 32'h0);
        send_item(KIND_REMOVE, 21'h10FFFF, 32'h0);
        send_item(KIND_REMOVE, 21'h10FFFF, 32'h0);
        send_item(KIND_REMOVE, 21'h0ABCDE, 32'h0);
        send_item(KIND_LOOKUP, 21'h10FFFF, 32'h0);
        send_item(KIND_LOOKUP, 21'h000001, 32'h0);
        send_item(KIND_INSERT, 21'h000001, 32'h12345678);
        send_item(KIND_INSERT, 21'h0AAAAA, 32'h87654321);
        send_item(KIND_SPARE,  21'h0AAAAA, 32'h0);
        send_item(KIND_LOOKUP, 21'h155555, 32'h0);
        send_item(KIND_INSERT, 21'h000000, 32'h00000001);
        send_item(KIND_LOOKUP, 21'h000000, 32'h0);

        // dense traffic on a few key clusters so lookups and removes hit
        repeat (450) mixed_op(85);

        // scattered inserts, with some lookups, until the node pool runs dry or 300 items are sent
        n = 0;
        while (sb.free_node < NODES_DEF && n < 300) begin
            if ($urandom_range(0, 4) != 0)
                send_item(KIND_INSERT, KEY_W'($urandom_range(0, 'h10FFFF)), $urandom());
            else
                send_item(KIND_LOOKUP, KEY_W'($urandom_range(0, 'h10FFFF)), $urandom());
            n++;
        end

        // full pool: new paths fail, existing ones still work
        repeat (200) mixed_op(70);

        s_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: radix_trie_codepoint_map_core.f
hw/rtl/rtcm_pkg.sv
hw/rtl/rtcm_slot_mem.sv
hw/rtl/rtcm_seq.sv
hw/rtl/radix_trie_codepoint_map_core.sv
tb/sv/tb_radix_trie_codepoint_map_core.sv
